### src/assert_macros.svh
// Assertion helpers shared by the RTL; all properties sample on clk_i and
// are disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SAC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define SAC_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);
`define SAC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define SAC_ASSERT(lbl, prop, msg)
`define SAC_ASSERT_IMP(lbl, pre, post, msg)
`define SAC_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

### src/sac_pkg.sv
`timescale 1ns / 1ps
package sac_pkg;

  // default sizing
  localparam int unsigned MAX_TEXT_DEF = 4096;
  localparam int unsigned ALPHABET_DEF = 26;

  // transaction modes
  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_COUNT  = 2'd2,
    MODE_READ   = 2'd3
  } mode_e;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_NOALLOC = 2'd2
  } status_e;

  // sequencer states
  typedef enum logic [5:0] {
    S_IDLE, S_CLR, S_ZERO,
    S_AP_START, S_AP_LEN, S_W1_RD, S_W1_CHK, S_QLEN,
    S_CL_RD, S_CL_WR, S_CL_LQ, S_CL_LW, S_CL_LQ2, S_CL_LC,
    S_W2_RD, S_W2_CHK, S_AP_FIN,
    S_CT_B0, S_CN_RL, S_CN_RB, S_CN_WB,
    S_CP_R0, S_CP_A0, S_CP_RD, S_CP_WR,
    S_CQ_RL, S_CQ_RB, S_CQ_WR,
    S_CM_RD, S_CM_L, S_CM_T, S_CM_N,
    S_CA_RO, S_CA_RV, S_CA_RL, S_CA_WR,
    S_RD, S_RD2, S_PUSH
  } state_e;

endpackage

### src/sac_ram.sv
`timescale 1ns / 1ps
// Simple dual-port RAM: one write port, one read port with registered data.
module sac_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/suffix_automaton_builder.sv
`timescale 1ns / 1ps
// Channel | Handshake             | Payload
// in      | in_valid_i/in_stall_o | mode_i, symbol_i, node_index_i
// out     | out_valid_o/out_stall_i | status_o, new_node_o, node_count_o,
//         |                       | node_length_o, link_node_o, has_link_o,
//         |                       | occurrences_o, next_node_o, has_next_o
// One transaction at a time; a small sequencer drives the one read port of each RAM.
// Read fetches the node's rows. Clear resets the root and blanks its row. Append
// blanks a fresh row, walks the suffix links and copies a row when a clone is made.
// Count clears the buckets, sorts the nodes by length, marks the text path and
// sums counts along suffix links, paced by the one read port on each node RAM.
// After reset the root row is initialised while stall is high.
// Stall holds the output register; a finished result waits until it is free.
`include "assert_macros.svh"
module suffix_automaton_builder #(
  parameter int unsigned MAX_TEXT = sac_pkg::MAX_TEXT_DEF,
  parameter int unsigned ALPHABET = sac_pkg::ALPHABET_DEF,
  localparam int unsigned NODE_CAP = 2 * MAX_TEXT,
  localparam int unsigned NW  = $clog2(NODE_CAP),
  localparam int unsigned NCW = $clog2(NODE_CAP + 1),
  localparam int unsigned LW  = $clog2(MAX_TEXT + 1),
  localparam int unsigned CW  = $clog2(MAX_TEXT + 2),
  localparam int unsigned SYW = $clog2(ALPHABET)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sac_pkg::mode_e      mode_i,
  input  logic [SYW-1:0]      symbol_i,
  input  logic [NW-1:0]       node_index_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sac_pkg::status_e    status_o,
  output logic [NW-1:0]       new_node_o,
  output logic [NCW-1:0]      node_count_o,
  output logic [LW-1:0]       node_length_o,
  output logic [NW-1:0]       link_node_o,
  output logic                has_link_o,
  output logic [CW-1:0]       occurrences_o,
  output logic [NW-1:0]       next_node_o,
  output logic                has_next_o
);

  import sac_pkg::*;

  localparam int unsigned TW       = $clog2(MAX_TEXT);
  localparam int unsigned TR_AW    = NW + SYW;
  localparam int unsigned TR_DEPTH = 1 << TR_AW;

  // control state
  state_e           state_q, state_d;
  mode_e            mode_q, mode_d;
  logic             init_q, init_d;
  logic [NCW-1:0]   alloc_q, alloc_d;
  logic [NW-1:0]    last_q, last_d;
  logic [LW-1:0]    tlen_q, tlen_d;
  logic             out_valid_q, out_valid_d;

  // working registers
  logic [SYW-1:0]   sym_q, sym_d;
  logic [NW-1:0]    idx_q, idx_d;
  logic [NW-1:0]    cur_q, cur_d, p_q, p_d, qn_q, qn_d, cl_q, cl_d, lk_q, lk_d;
  logic [LW-1:0]    lenp_q, lenp_d, lv_q, lv_d, i_q, i_d;
  logic [SYW-1:0]   k_q, k_d;
  logic [NCW-1:0]   v_q, v_d, acc_q, acc_d;
  logic [CW-1:0]    cv_q, cv_d;

  // pending result
  status_e          r_status_q, r_status_d;
  logic [NW-1:0]    r_new_q, r_new_d, r_link_q, r_link_d, r_next_q, r_next_d;
  logic [LW-1:0]    r_len_q, r_len_d;
  logic [CW-1:0]    r_occ_q, r_occ_d;
  logic             r_hlink_q, r_hlink_d, r_hnext_q, r_hnext_d;

  // output register
  status_e          o_status_q, o_status_d;
  logic [NW-1:0]    o_new_q, o_new_d, o_link_q, o_link_d, o_next_q, o_next_d;
  logic [NCW-1:0]   o_count_q, o_count_d;
  logic [LW-1:0]    o_len_q, o_len_d;
  logic [CW-1:0]    o_occ_q, o_occ_d;
  logic             o_hlink_q, o_hlink_d, o_hnext_q, o_hnext_d;

  // RAM ports
  logic             tr_we, lnk_we, len_we, cnt_we, txt_we, bkt_we, ord_we;
  logic [TR_AW-1:0] tr_waddr, tr_raddr;
  logic [NW-1:0]    tr_wdata, tr_rdata;
  logic [NW-1:0]    lnk_waddr, lnk_raddr, lnk_wdata, lnk_rdata;
  logic [NW-1:0]    len_waddr, len_raddr;
  logic [LW-1:0]    len_wdata, len_rdata;
  logic [NW-1:0]    cnt_waddr, cnt_raddr;
  logic [CW-1:0]    cnt_wdata, cnt_rdata;
  logic [TW-1:0]    txt_waddr, txt_raddr;
  logic [SYW-1:0]   txt_wdata, txt_rdata;
  logic [LW-1:0]    bkt_waddr, bkt_raddr;
  logic [NCW-1:0]   bkt_wdata, bkt_rdata;
  logic [NW-1:0]    ord_waddr, ord_raddr, ord_wdata, ord_rdata;

  // shared conditions
  logic             in_fire, push_ok, sym_in_ok, sym_ok, refused;
  logic             k_last, p_root, i_last, v_last, ca_last, len_match, mark_stop;
  logic [LW:0]      lenp_inc;
  logic [NCW-1:0]   bkt_dec, acc_sum;

  assign in_fire   = in_valid_i && (state_q == S_IDLE);
  assign push_ok   = !out_valid_q || !out_stall_i;
  assign sym_in_ok = {1'b0, symbol_i} < (SYW + 1)'(ALPHABET);
  assign sym_ok    = {1'b0, sym_q} < (SYW + 1)'(ALPHABET);
  assign refused   = (tlen_q >= LW'(MAX_TEXT)) ||
                     (({1'b0, alloc_q} + (NCW + 1)'(2)) > (NCW + 1)'(NODE_CAP));
  assign k_last    = (k_q == SYW'(ALPHABET - 1));
  assign p_root    = (p_q == '0);
  assign i_last    = (i_q == tlen_q);
  assign v_last    = ((v_q + NCW'(1)) == alloc_q);
  assign ca_last   = (v_q == NCW'(1));
  assign lenp_inc  = {1'b0, lenp_q} + (LW + 1)'(1);
  assign len_match = (lenp_inc == {1'b0, len_rdata});
  assign mark_stop = (tr_rdata == '0) || (NCW'(tr_rdata) >= alloc_q);
  assign bkt_dec   = bkt_rdata - NCW'(1);
  assign acc_sum   = acc_q + bkt_rdata;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          unique case (mode_i)
            MODE_CLEAR:  state_d = S_CLR;
            MODE_APPEND: state_d = (refused || !sym_in_ok) ? S_PUSH : S_AP_START;
            MODE_COUNT:  state_d = S_CT_B0;
            MODE_READ:   state_d = S_RD;
            default:     state_d = S_IDLE;
          endcase
        end
      end
      S_CLR:      state_d = S_ZERO;
      S_ZERO: begin
        if (k_last) begin
          if (mode_q == MODE_APPEND) state_d = S_W1_RD;
          else if (init_q)           state_d = S_IDLE;
          else                       state_d = S_PUSH;
        end
      end
      S_AP_START: state_d = S_AP_LEN;
      S_AP_LEN:   state_d = S_ZERO;
      S_W1_RD:    state_d = S_W1_CHK;
      S_W1_CHK: begin
        if (tr_rdata != '0) state_d = S_QLEN;
        else if (p_root)    state_d = S_AP_FIN;
        else                state_d = S_W1_RD;
      end
      S_QLEN:     state_d = len_match ? S_AP_FIN : S_CL_RD;
      S_CL_RD:    state_d = S_CL_WR;
      S_CL_WR:    state_d = k_last ? S_CL_LQ : S_CL_RD;
      S_CL_LQ:    state_d = S_CL_LW;
      S_CL_LW:    state_d = S_CL_LQ2;
      S_CL_LQ2:   state_d = S_CL_LC;
      S_CL_LC:    state_d = S_W2_RD;
      S_W2_RD:    state_d = S_W2_CHK;
      S_W2_CHK: begin
        if (tr_rdata == qn_q && !p_root) state_d = S_W2_RD;
        else                             state_d = S_AP_FIN;
      end
      S_AP_FIN:   state_d = S_PUSH;
      S_CT_B0:    state_d = i_last ? S_CN_RL : S_CT_B0;
      S_CN_RL:    state_d = S_CN_RB;
      S_CN_RB:    state_d = S_CN_WB;
      S_CN_WB:    state_d = v_last ? S_CP_R0 : S_CN_RL;
      S_CP_R0:    state_d = S_CP_A0;
      S_CP_A0:    state_d = (tlen_q == '0) ? S_CQ_RL : S_CP_RD;
      S_CP_RD:    state_d = S_CP_WR;
      S_CP_WR:    state_d = i_last ? S_CQ_RL : S_CP_RD;
      S_CQ_RL:    state_d = S_CQ_RB;
      S_CQ_RB:    state_d = S_CQ_WR;
      S_CQ_WR:    state_d = v_last ? S_CM_RD : S_CQ_RL;
      S_CM_RD:    state_d = S_CM_L;
      S_CM_L:     state_d = (len_rdata >= tlen_q) ? S_CA_RO : S_CM_T;
      S_CM_T:     state_d = S_CM_N;
      S_CM_N:     state_d = mark_stop ? S_CA_RO : S_CM_RD;
      S_CA_RO:    state_d = S_CA_RV;
      S_CA_RV: begin
        if (ord_rdata != '0) state_d = S_CA_RL;
        else if (ca_last)    state_d = S_PUSH;
        else                 state_d = S_CA_RO;
      end
      S_CA_RL:    state_d = S_CA_WR;
      S_CA_WR:    state_d = ca_last ? S_PUSH : S_CA_RO;
      S_RD:       state_d = (NCW'(idx_q) >= alloc_q) ? S_PUSH : S_RD2;
      S_RD2:      state_d = S_PUSH;
      S_PUSH:     state_d = push_ok ? S_IDLE : S_PUSH;
      default:    state_d = S_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    mode_d = mode_q;  init_d = init_q;  alloc_d = alloc_q;
    last_d = last_q;  tlen_d = tlen_q;
    sym_d = sym_q;  idx_d = idx_q;  cur_d = cur_q;  p_d = p_q;  qn_d = qn_q;
    cl_d = cl_q;  lk_d = lk_q;  lenp_d = lenp_q;  lv_d = lv_q;  i_d = i_q;
    k_d = k_q;  v_d = v_q;  acc_d = acc_q;  cv_d = cv_q;
    r_status_d = r_status_q;  r_new_d = r_new_q;  r_link_d = r_link_q;
    r_next_d = r_next_q;  r_len_d = r_len_q;  r_occ_d = r_occ_q;
    r_hlink_d = r_hlink_q;  r_hnext_d = r_hnext_q;
    o_status_d = o_status_q;  o_new_d = o_new_q;  o_link_d = o_link_q;
    o_next_d = o_next_q;  o_count_d = o_count_q;  o_len_d = o_len_q;
    o_occ_d = o_occ_q;  o_hlink_d = o_hlink_q;  o_hnext_d = o_hnext_q;
    out_valid_d = out_valid_q && out_stall_i;

    tr_we = 1'b0;   tr_waddr = '0;  tr_wdata = '0;  tr_raddr = '0;
    lnk_we = 1'b0;  lnk_waddr = '0; lnk_wdata = '0; lnk_raddr = '0;
    len_we = 1'b0;  len_waddr = '0; len_wdata = '0; len_raddr = '0;
    cnt_we = 1'b0;  cnt_waddr = '0; cnt_wdata = '0; cnt_raddr = '0;
    txt_we = 1'b0;  txt_waddr = '0; txt_wdata = '0; txt_raddr = '0;
    bkt_we = 1'b0;  bkt_waddr = '0; bkt_wdata = '0; bkt_raddr = '0;
    ord_we = 1'b0;  ord_waddr = '0; ord_wdata = '0; ord_raddr = '0;

    unique case (state_q)
      // capture transaction, clear pending result
      S_IDLE: begin
        if (in_fire) begin
          mode_d = mode_i;  sym_d = symbol_i;  idx_d = node_index_i;
          i_d = '0;
          r_status_d = STATUS_OK;  r_new_d = '0;  r_link_d = '0;  r_next_d = '0;
          r_len_d = '0;  r_occ_d = '0;  r_hlink_d = 1'b0;  r_hnext_d = 1'b0;
          if (mode_i == MODE_APPEND && refused) r_status_d = STATUS_FULL;
        end
      end
      // lone root
      S_CLR: begin
        alloc_d = NCW'(1);  last_d = '0;  tlen_d = '0;  cur_d = '0;  k_d = '0;
        len_we = 1'b1;  len_waddr = '0;  len_wdata = '0;
        cnt_we = 1'b1;  cnt_waddr = '0;  cnt_wdata = '0;
      end
      // blank the transition row of a fresh node
      S_ZERO: begin
        tr_we = 1'b1;  tr_waddr = {cur_q, k_q};  tr_wdata = '0;
        k_d = k_q + SYW'(1);
        if (k_last && mode_q != MODE_APPEND) init_d = 1'b0;
      end
      S_AP_START: begin
        cur_d = alloc_q[NW-1:0];  alloc_d = alloc_q + NCW'(1);  p_d = last_q;
        len_raddr = last_q;
      end
      S_AP_LEN: begin
        len_we = 1'b1;  len_waddr = cur_q;  len_wdata = len_rdata + LW'(1);
        lnk_we = 1'b1;  lnk_waddr = cur_q;  lnk_wdata = '0;
        cnt_we = 1'b1;  cnt_waddr = cur_q;  cnt_wdata = '0;
        k_d = '0;
      end
      // suffix-link walks: reads for both walks, then the first walk's check
      S_W1_RD, S_W2_RD: begin
        tr_raddr = {p_q, sym_q};  lnk_raddr = p_q;  len_raddr = p_q;
      end
      S_W1_CHK: begin
        if (tr_rdata == '0) begin
          tr_we = 1'b1;  tr_waddr = {p_q, sym_q};  tr_wdata = cur_q;
          p_d = lnk_rdata;
        end else begin
          qn_d = tr_rdata;  lenp_d = len_rdata;  len_raddr = tr_rdata;
        end
      end
      S_QLEN: begin
        if (len_match) begin
          lnk_we = 1'b1;  lnk_waddr = cur_q;  lnk_wdata = qn_q;
        end else begin
          cl_d = alloc_q[NW-1:0];  alloc_d = alloc_q + NCW'(1);  k_d = '0;
        end
      end
      // clone: copy the row, then link and count
      S_CL_RD: tr_raddr = {qn_q, k_q};
      S_CL_WR: begin
        tr_we = 1'b1;  tr_waddr = {cl_q, k_q};  tr_wdata = tr_rdata;
        k_d = k_q + SYW'(1);
      end
      S_CL_LQ: begin
        lnk_raddr = qn_q;  cnt_raddr = qn_q;
      end
      S_CL_LW: begin
        lnk_we = 1'b1;  lnk_waddr = cl_q;  lnk_wdata = lnk_rdata;
        cnt_we = 1'b1;  cnt_waddr = cl_q;  cnt_wdata = cnt_rdata;
        len_we = 1'b1;  len_waddr = cl_q;  len_wdata = LW'(lenp_inc);
      end
      S_CL_LQ2: begin
        lnk_we = 1'b1;  lnk_waddr = qn_q;  lnk_wdata = cl_q;
      end
      S_CL_LC: begin
        lnk_we = 1'b1;  lnk_waddr = cur_q;  lnk_wdata = cl_q;
      end
      // redirect transitions to the clone
      S_W2_CHK: begin
        if (tr_rdata == qn_q) begin
          tr_we = 1'b1;  tr_waddr = {p_q, sym_q};  tr_wdata = cl_q;
          p_d = lnk_rdata;
        end
      end
      S_AP_FIN: begin
        txt_we = 1'b1;  txt_waddr = tlen_q[TW-1:0];  txt_wdata = sym_q;
        tlen_d = tlen_q + LW'(1);  last_d = cur_q;  r_new_d = cur_q;
      end
      // count: clear buckets
      S_CT_B0: begin
        bkt_we = 1'b1;  bkt_waddr = i_q;  bkt_wdata = '0;
        i_d = i_q + LW'(1);  v_d = '0;
      end
      // histogram of lengths, counts cleared
      S_CN_RL: begin
        len_raddr = v_q[NW-1:0];
        cnt_we = 1'b1;  cnt_waddr = v_q[NW-1:0];  cnt_wdata = '0;
      end
      S_CN_RB, S_CQ_RB: begin
        lv_d = len_rdata;  bkt_raddr = len_rdata;
      end
      S_CN_WB: begin
        bkt_we = 1'b1;  bkt_waddr = lv_q;  bkt_wdata = bkt_rdata + NCW'(1);
        v_d = v_q + NCW'(1);
      end
      // prefix sums
      S_CP_R0: bkt_raddr = '0;
      S_CP_A0: begin
        acc_d = bkt_rdata;  i_d = LW'(1);  v_d = '0;
      end
      S_CP_RD: bkt_raddr = i_q;
      S_CP_WR: begin
        acc_d = acc_sum;  bkt_we = 1'b1;  bkt_waddr = i_q;  bkt_wdata = acc_sum;
        i_d = i_q + LW'(1);  v_d = '0;
      end
      // place nodes in length order
      S_CQ_RL: len_raddr = v_q[NW-1:0];
      S_CQ_WR: begin
        bkt_we = 1'b1;  bkt_waddr = lv_q;  bkt_wdata = bkt_dec;
        ord_we = 1'b1;  ord_waddr = bkt_dec[NW-1:0];  ord_wdata = v_q[NW-1:0];
        v_d = v_q + NCW'(1);  p_d = '0;
      end
      // mark the nodes on the whole-text path
      S_CM_RD: begin
        cnt_we = 1'b1;  cnt_waddr = p_q;  cnt_wdata = CW'(1);
        len_raddr = p_q;
      end
      S_CM_L: begin
        txt_raddr = len_rdata[TW-1:0];  v_d = alloc_q;
      end
      S_CM_T: tr_raddr = {p_q, txt_rdata};
      S_CM_N: p_d = tr_rdata;
      // propagate counts along suffix links, longest first
      S_CA_RO: ord_raddr = NW'(v_q - NCW'(1));
      S_CA_RV: begin
        lnk_raddr = ord_rdata;  cnt_raddr = ord_rdata;
        if (ord_rdata == '0) v_d = v_q - NCW'(1);
      end
      S_CA_RL: begin
        lk_d = lnk_rdata;  cv_d = cnt_rdata;  cnt_raddr = lnk_rdata;
      end
      S_CA_WR: begin
        cnt_we = 1'b1;  cnt_waddr = lk_q;  cnt_wdata = cnt_rdata + cv_q;
        v_d = v_q - NCW'(1);
      end
      // node read
      S_RD: begin
        r_new_d = idx_q;
        if (NCW'(idx_q) >= alloc_q) r_status_d = STATUS_NOALLOC;
        len_raddr = idx_q;  lnk_raddr = idx_q;  cnt_raddr = idx_q;
        tr_raddr = {idx_q, sym_q};
      end
      S_RD2: begin
        r_len_d = len_rdata;  r_occ_d = cnt_rdata;
        if (idx_q != '0) begin
          r_link_d = lnk_rdata;  r_hlink_d = 1'b1;
        end
        if (sym_ok && tr_rdata != '0) begin
          r_next_d = tr_rdata;  r_hnext_d = 1'b1;
        end
      end
      // hand the result to the output register
      S_PUSH: begin
        if (push_ok) begin
          out_valid_d = 1'b1;
          o_status_d = r_status_q;  o_new_d = r_new_q;  o_count_d = alloc_q;
          o_len_d = r_len_q;  o_link_d = r_link_q;  o_hlink_d = r_hlink_q;
          o_occ_d = r_occ_q;  o_next_d = r_next_q;  o_hnext_d = r_hnext_q;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      mode_q      <= MODE_CLEAR;
      init_q      <= 1'b1;
      alloc_q     <= NCW'(1);
      last_q      <= '0;
      tlen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      init_q      <= init_d;
      alloc_q     <= alloc_d;
      last_q      <= last_d;
      tlen_q      <= tlen_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working and payload registers
  always_ff @(posedge clk_i) begin
    sym_q <= sym_d;  idx_q <= idx_d;  cur_q <= cur_d;  p_q <= p_d;  qn_q <= qn_d;
    cl_q <= cl_d;  lk_q <= lk_d;  lenp_q <= lenp_d;  lv_q <= lv_d;  i_q <= i_d;
    k_q <= k_d;  v_q <= v_d;  acc_q <= acc_d;  cv_q <= cv_d;
    r_status_q <= r_status_d;  r_new_q <= r_new_d;  r_link_q <= r_link_d;
    r_next_q <= r_next_d;  r_len_q <= r_len_d;  r_occ_q <= r_occ_d;
    r_hlink_q <= r_hlink_d;  r_hnext_q <= r_hnext_d;
    o_status_q <= o_status_d;  o_new_q <= o_new_d;  o_link_q <= o_link_d;
    o_next_q <= o_next_d;  o_count_q <= o_count_d;  o_len_q <= o_len_d;
    o_occ_q <= o_occ_d;  o_hlink_q <= o_hlink_d;  o_hnext_q <= o_hnext_d;
  end

  // node and text memories
  sac_ram #(.WIDTH(NW), .DEPTH(TR_DEPTH)) u_trans (
    .clk_i, .we_i(tr_we), .waddr_i(tr_waddr), .wdata_i(tr_wdata),
    .raddr_i(tr_raddr), .rdata_o(tr_rdata)
  );
  sac_ram #(.WIDTH(NW), .DEPTH(NODE_CAP)) u_link (
    .clk_i, .we_i(lnk_we), .waddr_i(lnk_waddr), .wdata_i(lnk_wdata),
    .raddr_i(lnk_raddr), .rdata_o(lnk_rdata)
  );
  sac_ram #(.WIDTH(LW), .DEPTH(NODE_CAP)) u_length (
    .clk_i, .we_i(len_we), .waddr_i(len_waddr), .wdata_i(len_wdata),
    .raddr_i(len_raddr), .rdata_o(len_rdata)
  );
  sac_ram #(.WIDTH(CW), .DEPTH(NODE_CAP)) u_count (
    .clk_i, .we_i(cnt_we), .waddr_i(cnt_waddr), .wdata_i(cnt_wdata),
    .raddr_i(cnt_raddr), .rdata_o(cnt_rdata)
  );
  sac_ram #(.WIDTH(SYW), .DEPTH(MAX_TEXT)) u_text (
    .clk_i, .we_i(txt_we), .waddr_i(txt_waddr), .wdata_i(txt_wdata),
    .raddr_i(txt_raddr), .rdata_o(txt_rdata)
  );
  sac_ram #(.WIDTH(NCW), .DEPTH(MAX_TEXT + 1)) u_bucket (
    .clk_i, .we_i(bkt_we), .waddr_i(bkt_waddr), .wdata_i(bkt_wdata),
    .raddr_i(bkt_raddr), .rdata_o(bkt_rdata)
  );
  sac_ram #(.WIDTH(NW), .DEPTH(NODE_CAP)) u_order (
    .clk_i, .we_i(ord_we), .waddr_i(ord_waddr), .wdata_i(ord_wdata),
    .raddr_i(ord_raddr), .rdata_o(ord_rdata)
  );

  // outputs
  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = o_status_q;
  assign new_node_o    = o_new_q;
  assign node_count_o  = o_count_q;
  assign node_length_o = o_len_q;
  assign link_node_o   = o_link_q;
  assign has_link_o    = o_hlink_q;
  assign occurrences_o = o_occ_q;
  assign next_node_o   = o_next_q;
  assign has_next_o    = o_hnext_q;

  // checks
  `SAC_ASSERT(a_alloc_range, (alloc_q >= NCW'(1)) && (alloc_q <= NCW'(NODE_CAP)), "node count out of range")
  `SAC_ASSERT(a_tlen_range, tlen_q <= LW'(MAX_TEXT), "text length beyond store")
  `SAC_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, state_q != S_IDLE, "accepted transaction not started")
  `SAC_ASSERT_IMP(a_load_from_push, $rose(out_valid_q), $past(state_q) == S_PUSH, "result raised outside push")

endmodule
